[rtl/core/sha256_block_hash_assert.svh]
// Assertion macros for the SHA-256 block hash core.
// Used by sha256_block_hash; relies on clk_i and rst_ni in the including module.
`ifndef SHA256_BLOCK_HASH_ASSERT_SVH
`define SHA256_BLOCK_HASH_ASSERT_SVH

`ifndef SYNTHESIS
`define SHA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("sha256 assertion failed");
`define SHA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("sha256 assertion failed");
`else
`define SHA_ASSERT(lbl, prop)
`define SHA_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

[rtl/core/sha256_pkg.sv]
// Shared types, constants and round functions of the SHA-256 block hash core.
// No dependencies.
`timescale 1ns / 1ps

package sha256_pkg;

  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds     = 64;
  localparam int unsigned HashWords  = 8;

  typedef logic [31:0] word_t;
  typedef logic [HashWords-1:0][31:0] hash_t;
  typedef logic [BlockWords-1:0][31:0] block_t;

  typedef struct packed {
    logic load;
    logic step;
  } seq_ctrl_t;

  typedef enum logic [3:0] {
    ST_LOAD  = 4'b0001,
    ST_ROUND = 4'b0010,
    ST_ADD   = 4'b0100,
    ST_OUT   = 4'b1000
  } state_e;

  localparam hash_t InitHash = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam word_t RoundK [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t byte_swap(input word_t x);
    byte_swap = {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage

[rtl/core/sha256_block_hash.sv]
// SHA-256 block hash: 16 words a cycle each, then 64 rounds on one shared round unit,
// then chaining add; emits the byte-swapped digest after the final block.
// The first digest item follows the rounds and the chaining add of the final block.
// Words, rounds and add of a block run in turn and blocks do not overlap, set by the
// single round unit; ready is low during rounds, add and digest output.
// Reset: asynchronous, active low; hash words take the initial hash, counters clear.
`timescale 1ns / 1ps

module sha256_block_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // [31:0] msg_word
  input  logic [0:0]  s_axis_tuser_i,  // [0] message_start
  input  logic        s_axis_tlast_i,  // message_end
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,  // [31:0] digest_word, [34:32] digest_index
  output logic        m_axis_tlast_o   // digest_last
);

  `include "sha256_block_hash_assert.svh"

  sha256_pkg::state_e    state_q, state_d;
  sha256_pkg::hash_t     hash_q;
  sha256_pkg::hash_t     vars;
  sha256_pkg::word_t     wt;
  sha256_pkg::seq_ctrl_t sched_ctrl;
  sha256_pkg::seq_ctrl_t round_ctrl;
  logic [3:0]            pos_q;
  logic [5:0]            rnd_q;
  logic [2:0]            out_idx_q;
  logic                  end_q;
  logic                  in_acc;
  logic                  out_acc;
  logic                  out_done;
  logic                  in_round;
  logic                  blk_done;

  assign s_axis_tready_o = (state_q == sha256_pkg::ST_LOAD);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign blk_done        = in_acc && !s_axis_tuser_i[0] && (pos_q == 4'd15);
  assign m_axis_tvalid_o = (state_q == sha256_pkg::ST_OUT);
  assign out_acc         = m_axis_tvalid_o && m_axis_tready_i;
  assign out_done        = out_acc && (out_idx_q == 3'd7);
  assign in_round        = (state_q == sha256_pkg::ST_ROUND);

  assign sched_ctrl = '{load: in_acc, step: in_round};
  assign round_ctrl = '{load: blk_done, step: in_round};

  sha256_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (sched_ctrl),
    .word_i (s_axis_tdata_i),
    .wt_o   (wt)
  );

  sha256_round u_round (
    .clk_i  (clk_i),
    .ctrl_i (round_ctrl),
    .init_i (hash_q),
    .k_i    (sha256_pkg::RoundK[rnd_q]),
    .wt_i   (wt),
    .vars_o (vars)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      sha256_pkg::ST_LOAD: begin
        if (blk_done) state_d = sha256_pkg::ST_ROUND;
      end
      sha256_pkg::ST_ROUND: begin
        if (rnd_q == 6'd63) state_d = sha256_pkg::ST_ADD;
      end
      sha256_pkg::ST_ADD: begin
        state_d = end_q ? sha256_pkg::ST_OUT : sha256_pkg::ST_LOAD;
      end
      sha256_pkg::ST_OUT: begin
        if (out_acc && out_idx_q == 3'd7) state_d = sha256_pkg::ST_LOAD;
      end
      default: state_d = sha256_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sha256_pkg::ST_LOAD;
      hash_q    <= sha256_pkg::InitHash;
      pos_q     <= '0;
      rnd_q     <= '0;
      out_idx_q <= '0;
      end_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        if (s_axis_tuser_i[0]) begin
          hash_q <= sha256_pkg::InitHash;
          pos_q  <= 4'd1;
        end else begin
          pos_q <= pos_q + 4'd1;
        end
        end_q <= s_axis_tlast_i;
      end
      if (state_q == sha256_pkg::ST_ROUND) begin
        rnd_q <= rnd_q + 6'd1;
      end
      if (state_q == sha256_pkg::ST_ADD) begin
        for (int i = 0; i < sha256_pkg::HashWords; i++) begin
          hash_q[i] <= hash_q[i] + vars[i];
        end
      end
      if (out_acc) begin
        out_idx_q <= out_idx_q + 3'd1;
      end
    end
  end

  assign m_axis_tdata_o = {5'b0, out_idx_q, sha256_pkg::byte_swap(hash_q[out_idx_q])};
  assign m_axis_tlast_o = (out_idx_q == 3'd7);

  `SHA_ASSERT(a_no_overlap, !(s_axis_tready_o && m_axis_tvalid_o))
  `SHA_ASSERT(a_blk_starts_rounds, blk_done |=> (in_round && rnd_q == 6'd0))
  `SHA_ASSERT(a_rounds_end, (in_round && rnd_q == 6'd63) |=> (state_q == sha256_pkg::ST_ADD))
  `SHA_ASSERT(a_out_ends, out_done |=> (state_q == sha256_pkg::ST_LOAD && out_idx_q == 3'd0))
  `SHA_ASSERT(a_idx_idle, (state_q != sha256_pkg::ST_OUT) |-> (out_idx_q == 3'd0))

endmodule

[rtl/core/sha256_sched.sv]
// Message schedule: 16-word shift line that takes the block words and expands them.
// Depends on sha256_pkg.
`timescale 1ns / 1ps

module sha256_sched (
  input  logic                  clk_i,
  input  sha256_pkg::seq_ctrl_t ctrl_i,
  input  sha256_pkg::word_t     word_i,
  output sha256_pkg::word_t     wt_o
);

  sha256_pkg::block_t w_q;
  sha256_pkg::word_t  w_next;

  assign w_next = sha256_pkg::small_sigma1(w_q[14]) + w_q[9]
                + sha256_pkg::small_sigma0(w_q[1]) + w_q[0];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      w_q <= {word_i, w_q[sha256_pkg::BlockWords-1:1]};
    end else if (ctrl_i.step) begin
      w_q <= {w_next, w_q[sha256_pkg::BlockWords-1:1]};
    end
  end

  assign wt_o = w_q[0];

endmodule

[rtl/core/sha256_round.sv]
// Compression round unit: working variables a..h and one round per step.
// Depends on sha256_pkg.
`timescale 1ns / 1ps

module sha256_round (
  input  logic                  clk_i,
  input  sha256_pkg::seq_ctrl_t ctrl_i,
  input  sha256_pkg::hash_t     init_i,
  input  sha256_pkg::word_t     k_i,
  input  sha256_pkg::word_t     wt_i,
  output sha256_pkg::hash_t     vars_o
);

  sha256_pkg::hash_t v_q;
  sha256_pkg::hash_t v_d;
  sha256_pkg::word_t t1;
  sha256_pkg::word_t t2;

  always_comb begin
    t1 = v_q[7] + sha256_pkg::big_sigma1(v_q[4])
       + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + k_i + wt_i;
    t2 = sha256_pkg::big_sigma0(v_q[0])
       + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
    v_d    = {v_q[6:4], v_q[3] + t1, v_q[2:0], t1 + t2};
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      v_q <= init_i;
    end else if (ctrl_i.step) begin
      v_q <= v_d;
    end
  end

  assign vars_o = v_q;

endmodule

[dv/tb_sha256_block_hash.sv]
// Self-checking testbench for sha256_block_hash: streams message words, predicts each
// digest by its own SHA-256 compression or a stored abc digest, checks items in order.
// Depends on sha256_pkg and sha256_block_hash.
`timescale 1ns / 1ps

module tb_sha256_block_hash;

  typedef sha256_pkg::word_t word_t;

  localparam int TotalItems  = 370;
  localparam int CycleLimit  = 200000;
  localparam int HoldCycles  = 600;
  localparam int DrainCycles = 150;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_item_t;

  typedef struct packed {
    logic [31:0] word;
    logic        start;
    logic        fin;
    logic        known;
  } dir_row_t;

  localparam word_t IvTab [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t KTab [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // digest of "abc", bytes of each word already reversed
  localparam word_t AbcDigest [8] = '{
    32'hbf1678ba, 32'heacf018f, 32'hde404141, 32'h2322ae5d,
    32'ha36103b0, 32'h9c7a1796, 32'h61ff10b4, 32'had1500f2
  };

  // word, start, end, known digest
  localparam dir_row_t DirTab [25] = '{
    '{32'h61626380, 1'b0, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b1, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'h00000018, 1'b0, 1'b1, 1'b1},
    '{32'hffffffff, 1'b0, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'hffffffff, 1'b0, 1'b1, 1'b0},
    '{32'h12345678, 1'b1, 1'b0, 1'b0},
    '{32'hffffffff, 1'b0, 1'b0, 1'b0},
    '{32'h00000000, 1'b1, 1'b1, 1'b0},
    '{32'ha5a5a5a5, 1'b0, 1'b0, 1'b0},
    '{32'h5a5a5a5a, 1'b0, 1'b0, 1'b0},
    '{32'hffffffff, 1'b0, 1'b0, 1'b0}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i;   // [31:0] msg_word
  logic [0:0]  s_axis_tuser_i;   // [0] message_start
  logic        s_axis_tlast_i;   // message_end
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [39:0] m_axis_tdata_o;   // [31:0] digest_word, [34:32] digest_index
  logic        m_axis_tlast_o;   // digest_last

  word_t        hash_st [8];
  word_t        sched_st [16];
  logic [3:0]   word_pos;
  digest_item_t pending_digest_q [$];
  int           items_sent;
  int           tx_phase;
  int           err_cnt;
  int           cycle_cnt;

  sha256_block_hash i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic word_t ror32(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t swap_bytes(input word_t x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  function automatic void compress_state();
    word_t v [8];
    word_t wt, t1, t2, w2, w15;
    for (int i = 0; i < 8; i++) v[i] = hash_st[i];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        wt = sched_st[t];
      end else begin
        w2  = sched_st[(t - 2) & 15];
        w15 = sched_st[(t - 15) & 15];
        wt  = (ror32(w2, 17) ^ ror32(w2, 19) ^ (w2 >> 10)) + sched_st[(t - 7) & 15]
            + (ror32(w15, 7) ^ ror32(w15, 18) ^ (w15 >> 3)) + sched_st[t & 15];
        sched_st[t & 15] = wt;
      end
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTab[t] + wt;
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_st[i] = hash_st[i] + v[i];
  endfunction

  task automatic absorb_word(input word_t w, input logic st, input logic fin, input bit known);
    digest_item_t d;
    if (st) begin
      hash_st  = IvTab;
      word_pos = '0;
    end
    sched_st[word_pos] = w;
    if (word_pos != 4'd15) begin
      word_pos = word_pos + 4'd1;
    end else begin
      word_pos = '0;
      compress_state();
      if (fin) begin
        for (int i = 0; i < 8; i++) begin
          d.word = known ? AbcDigest[i] : swap_bytes(hash_st[i]);
          d.idx  = 3'(i);
          d.last = (i == 7);
          pending_digest_q.push_back(d);
        end
      end
    end
  endtask

  task automatic send_item(input word_t w, input logic st, input logic fin, input bit known);
    int pct;
    pct = (tx_phase == 0) ? 19 : (tx_phase == 1) ? 85 : 0;
    while ($urandom_range(0, 99) < pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= w;
    s_axis_tuser_i  <= st;
    s_axis_tlast_i  <= fin;
    do @(posedge clk_i); while (!s_axis_tready_o);
    absorb_word(w, st, fin, known);
    items_sent++;
    tx_phase = (items_sent * 3 / TotalItems > 2) ? 2 : items_sent * 3 / TotalItems;
  endtask

  function automatic word_t pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'h00000000;
      1:       return 32'hffffffff;
      default: return $urandom;
    endcase
  endfunction

  // stimulus
  initial begin : tx_drive
    int nwords;
    hash_st         = IvTab;
    word_pos        = '0;
    items_sent      = 0;
    tx_phase        = 0;
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= '0;
    s_axis_tlast_i  <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (DirTab[r]) begin
      send_item(DirTab[r].word, DirTab[r].start, DirTab[r].fin, DirTab[r].known);
    end
    while (items_sent < TotalItems) begin
      if ($urandom_range(0, 9) < 8) begin
        // well-formed message of one to three blocks
        nwords = 16 * (($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1);
        for (int k = 0; k < nwords; k++) begin
          send_item(pick_word(), k == 0, k == nwords - 1, 1'b0);
        end
      end else begin
        nwords = $urandom_range(1, 20);
        for (int k = 0; k < nwords; k++) begin
          send_item(pick_word(), $urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)), 1'b0);
        end
      end
    end
    s_axis_tvalid_i <= 1'b0;
    while (pending_digest_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0 && pending_digest_q.size() == 0) begin
      $display("tb_sha256_block_hash: PASS");
    end else begin
      $display("tb_sha256_block_hash: FAIL");
    end
    $finish;
  end

  // output backpressure; one long hold-off when the last phase begins
  initial begin : rx_drive
    int hold_left;
    bit hold_done;
    int pct;
    hold_left = 0;
    hold_done = 0;
    m_axis_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      pct = (tx_phase == 0) ? 85 : (tx_phase == 1) ? 19 : 0;
      if (tx_phase == 2 && !hold_done) begin
        hold_left = HoldCycles;
        hold_done = 1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(0, 99) >= pct);
      end
    end
  end

  initial err_cnt = 0;

  always @(posedge clk_i) begin
    digest_item_t exp_d;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_digest_q.size() == 0) begin
        $display("%0t: unexpected digest item word=%h idx=%0d last=%b", $time,
                 m_axis_tdata_o[31:0], m_axis_tdata_o[34:32], m_axis_tlast_o);
        err_cnt++;
      end else begin
        exp_d = pending_digest_q.pop_front();
        if (m_axis_tdata_o[31:0] !== exp_d.word) begin
          $display("%0t: digest_word expected %h actual %h", $time, exp_d.word,
                   m_axis_tdata_o[31:0]);
          err_cnt++;
        end
        if (m_axis_tdata_o[34:32] !== exp_d.idx) begin
          $display("%0t: digest_index expected %0d actual %0d", $time, exp_d.idx,
                   m_axis_tdata_o[34:32]);
          err_cnt++;
        end
        if (m_axis_tlast_o !== exp_d.last) begin
          $display("%0t: digest_last expected %b actual %b", $time, exp_d.last,
                   m_axis_tlast_o);
          err_cnt++;
        end
      end
    end
  end

  initial cycle_cnt = 0;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("tb_sha256_block_hash: FAIL");
      $finish;
    end
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/sha256_pkg.sv
rtl/core/sha256_sched.sv
rtl/core/sha256_round.sv
rtl/core/sha256_block_hash.sv
dv/tb_sha256_block_hash.sv
